// ----- rtl/imf_pkg.sv -----
// ----------------------------------------------------------------------------
// imf_pkg
// Shared sizes and register codes for the image median filter.
// ----------------------------------------------------------------------------
package imf_pkg;

  // default capacity of the block
  localparam int unsigned IMF_MAX_WIDTH    = 1024;
  localparam int unsigned IMF_MAX_HEIGHT   = 4096;
  localparam int unsigned IMF_MAX_FILTER   = 7;
  localparam int unsigned IMF_MAX_CHANNELS = 4;

  // configuration port layout
  localparam int unsigned IMF_CFG_IDX_W  = 3;
  localparam int unsigned IMF_CFG_DATA_W = 13;

  typedef enum logic [IMF_CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_FILTER_HEIGHT = 3'd3,
    REG_FILTER_WIDTH  = 3'd4
  } imf_reg_t;

endpackage

// ----- rtl/imf_ram.sv -----
// ----------------------------------------------------------------------------
// imf_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module imf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/image_median_filter.sv -----
// ----------------------------------------------------------------------------
// image_median_filter
// Streaming 2-D median filter over interleaved 8-bit raster samples.
// ----------------------------------------------------------------------------
// Accepts one sample per clock and sustains one request per cycle unless
// out_ready stalls the output. Each sample reads its column history (the
// last MAX_FILTER-1 samples of the same column and channel) from a
// line-store RAM, appends itself and writes it back; a same-cycle hit on the
// entry being written is forwarded. The new column is shifted into that
// channel's window, and the rank (H*W)/2 element is found by a pipelined
// compare / count / select datapath. Border positions give no result.
// Any register write restarts the frame at row 0, column 0, channel 0.
module image_median_filter
  import imf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH    = IMF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT   = IMF_MAX_HEIGHT,
  parameter int unsigned MAX_FILTER   = IMF_MAX_FILTER,
  parameter int unsigned MAX_CHANNELS = IMF_MAX_CHANNELS,
  localparam int unsigned CW  = $clog2(MAX_WIDTH),
  localparam int unsigned RW  = $clog2(MAX_HEIGHT),
  localparam int unsigned CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [IMF_CFG_IDX_W-1:0]  cfg_index,
  input  logic [IMF_CFG_DATA_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_median,
  output logic [RW-1:0]             out_row,
  output logic [CW-1:0]             out_col,
  output logic [CHW-1:0]            out_channel,
  output logic                      out_frame_last
);

  localparam int unsigned F     = MAX_FILTER;
  localparam int unsigned N     = F * F;
  localparam int unsigned NCW   = $clog2(N + 1);
  localparam int unsigned FSW   = $clog2(F + 1);
  localparam int unsigned WDW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HTW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned NCHW  = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned HW    = (F - 1) * 8;

  // --------------------------------------------------------------------------
  // configuration registers, saturated before use
  logic [10:0] img_w_r;
  logic [12:0] img_h_r;
  logic [2:0]  nch_r, fh_r, fw_r;
  logic        cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index <= REG_FILTER_WIDTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= 11'd1024;
      img_h_r <= 13'd4096;
      nch_r   <= 3'd1;
      fh_r    <= 3'd3;
      fw_r    <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   img_w_r <= cfg_data[10:0];
        REG_IMAGE_HEIGHT:  img_h_r <= cfg_data;
        REG_CHANNEL_COUNT: nch_r   <= cfg_data[2:0];
        REG_FILTER_HEIGHT: fh_r    <= cfg_data[2:0];
        REG_FILTER_WIDTH:  fw_r    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic [WDW-1:0]  wd;
  logic [HTW-1:0]  ht;
  logic [NCHW-1:0] nc;
  logic [FSW-1:0]  fh, fw;
  logic [NCW-1:0]  rank;

  always_comb begin
    wd = (img_w_r == 0) ? WDW'(1) :
         (32'(img_w_r) > MAX_WIDTH) ? WDW'(MAX_WIDTH) : WDW'(img_w_r);
    ht = (img_h_r == 0) ? HTW'(1) :
         (32'(img_h_r) > MAX_HEIGHT) ? HTW'(MAX_HEIGHT) : HTW'(img_h_r);
    nc = (nch_r == 0) ? NCHW'(1) :
         (32'(nch_r) > MAX_CHANNELS) ? NCHW'(MAX_CHANNELS) : NCHW'(nch_r);
    fh = (fh_r == 0) ? FSW'(1) : (32'(fh_r) > F) ? FSW'(F) : FSW'(fh_r);
    fw = (fw_r == 0) ? FSW'(1) : (32'(fw_r) > F) ? FSW'(F) : FSW'(fw_r);
    rank = NCW'((32'(fh) * 32'(fw)) >> 1);
  end

  // window element mask: column k (newest first), depth d (newest first)
  logic [N-1:0] wmask;
  always_comb begin
    for (int k = 0; k < F; k++) begin
      for (int d = 0; d < F; d++) begin
        wmask[k*F+d] = (32'(k) < 32'(fw)) && (32'(d) < 32'(fh));
      end
    end
  end

  // --------------------------------------------------------------------------
  // pipeline handshake: each stage moves when the next one has room
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic acc;

  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign acc      = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // position counters of the next sample
  logic [RW-1:0]  row_r, row_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [CHW-1:0] chan_r, chan_nxt;
  logic           last_ch, last_col, last_row;

  assign last_ch  = (32'(chan_r) + 1) >= 32'(nc);
  assign last_col = (32'(col_r) + 1) >= 32'(wd);
  assign last_row = (32'(row_r) + 1) >= 32'(ht);

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    chan_nxt = CHW'(32'(chan_r) + 1);
    if (last_ch) begin
      chan_nxt = '0;
      col_nxt  = CW'(32'(col_r) + 1);
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : RW'(32'(row_r) + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      row_r  <= '0;
      col_r  <= '0;
      chan_r <= '0;
    end else if (acc) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      chan_r <= chan_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1 capture: request metadata, history read issued on accept
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  s1_addr_r;
  logic [7:0]     s1_sample_r;
  logic [CHW-1:0] s1_ch_r;
  logic [RW-1:0]  s1_row_r;
  logic [CW-1:0]  s1_col_r;
  logic           s1_prod_r, s1_last_r;
  logic           fwd_r;
  logic [HW-1:0]  fwd_hist_r;
  logic [HW-1:0]  ram_rdata;
  logic           wr_en;
  logic [HW-1:0]  new_hist;

  assign rd_addr = AW'(32'(col_r) * MAX_CHANNELS + 32'(chan_r));
  assign wr_en   = v1_r && rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      fwd_r <= 1'b0;
    end else if (rdy1) begin
      v1_r  <= acc;
      fwd_r <= acc && wr_en && (rd_addr == s1_addr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_addr_r   <= rd_addr;
      s1_sample_r <= in_sample;
      s1_ch_r     <= chan_r;
      s1_row_r    <= RW'(32'(row_r) - 32'(fh >> 1));
      s1_col_r    <= CW'(32'(col_r) - 32'(fw >> 1));
      s1_prod_r   <= ((32'(row_r) + 1) >= 32'(fh)) && ((32'(col_r) + 1) >= 32'(fw));
      s1_last_r   <= last_row && last_col && last_ch;
      fwd_hist_r  <= new_hist;
    end
  end

  imf_ram #(
    .WIDTH (HW),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr_r),
    .wdata (new_hist),
    .re    (acc),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // stage 1 work: extend column, shift into the channel window
  logic [HW-1:0]  old_hist;
  logic [F*8-1:0] new_column;
  logic [N*8-1:0] win_r [MAX_CHANNELS];
  logic [N*8-1:0] win_nxt;

  assign old_hist   = fwd_r ? fwd_hist_r : ram_rdata;
  assign new_column = {old_hist, s1_sample_r};
  assign new_hist   = new_column[HW-1:0];
  assign win_nxt    = {win_r[s1_ch_r][(N-F)*8-1:0], new_column};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_r[s1_ch_r] <= win_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stages 2..5: window, compare matrix, rank counts, selection
  logic [N*8-1:0] s2_win_r, s3_win_r, s4_win_r;
  logic [RW-1:0]  s2_row_r, s3_row_r, s4_row_r;
  logic [CW-1:0]  s2_col_r, s3_col_r, s4_col_r;
  logic [CHW-1:0] s2_ch_r, s3_ch_r, s4_ch_r;
  logic           s2_last_r, s3_last_r, s4_last_r;
  logic [N-1:0]   lt_nxt [N];
  logic [N-1:0]   lt_r [N];
  logic [NCW-1:0] cnt_nxt [N];
  logic [NCW-1:0] cnt_r [N];
  logic [7:0]     med_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= v1_r && s1_prod_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // element j ranks below element i; ties broken by position
  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        lt_nxt[i][j] = wmask[j] &&
          ((s2_win_r[j*8 +: 8] < s2_win_r[i*8 +: 8]) ||
           ((s2_win_r[j*8 +: 8] == s2_win_r[i*8 +: 8]) && (j < i)));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      cnt_nxt[i] = NCW'($countones(lt_r[i]));
    end
  end

  // exactly one masked element sits at the target rank
  always_comb begin
    med_nxt = '0;
    for (int i = 0; i < N; i++) begin
      if (wmask[i] && (cnt_r[i] == rank)) begin
        med_nxt = med_nxt | s4_win_r[i*8 +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      s2_win_r  <= win_nxt;
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
      s2_ch_r   <= s1_ch_r;
      s2_last_r <= s1_last_r;
    end
    if (rdy3 && v2_r) begin
      lt_r      <= lt_nxt;
      s3_win_r  <= s2_win_r;
      s3_row_r  <= s2_row_r;
      s3_col_r  <= s2_col_r;
      s3_ch_r   <= s2_ch_r;
      s3_last_r <= s2_last_r;
    end
    if (rdy4 && v3_r) begin
      cnt_r     <= cnt_nxt;
      s4_win_r  <= s3_win_r;
      s4_row_r  <= s3_row_r;
      s4_col_r  <= s3_col_r;
      s4_ch_r   <= s3_ch_r;
      s4_last_r <= s3_last_r;
    end
    if (rdy5 && v4_r) begin
      out_median     <= med_nxt;
      out_row        <= s4_row_r;
      out_col        <= s4_col_r;
      out_channel    <= s4_ch_r;
      out_frame_last <= s4_last_r;
    end
  end

  assign out_valid = v5_r;

  // --------------------------------------------------------------------------
  // checks
  a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> v1_r)
    else $error("forward flag without an item in stage 1");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (row_r == 0) && (col_r == 0) && (chan_r == 0))
    else $error("register write did not restart the frame");

  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(chan_r) < 32'(nc)) && (32'(col_r) < 32'(wd)))
    else $error("position counter out of range");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> v1_r)
    else $error("accepted request missing from stage 1");

endmodule
